[design/cset_pkg.sv]
package cset_pkg;

    // Fixed field widths of the item and result ports.
    localparam int OP_W   = 2;
    localparam int ID_W   = 7;
    localparam int TS_W   = 32;
    localparam int ST_W   = 2;
    localparam int TOT_W  = 48;
    localparam int CFG_W  = 8;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_NUM_FUNCS = 2'd0;
    localparam logic [CFG_W-1:0] NUM_FUNCS_RST = 8'd128;

    // Defaults for the top-level parameters.
    localparam int MAX_FUNCS_DEF   = 128;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Source of the total field when a result is issued.
    typedef enum logic [1:0] {
        RES_FAULT = 2'd0,
        RES_ZERO  = 2'd1,
        RES_SPAN  = 2'd2,
        RES_TOTAL = 2'd3
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch_in;
        logic     clr_wr;
        logic     push;
        logic     stk_rd;
        logic     pop;
        logic     span_ld;
        logic     tot_rd_id;
        logic     tot_wr_add;
        logic     top_ld;
        logic     tot_rd_top;
        logic     tot_wr_sub;
        logic     finish;
        res_sel_t res_sel;
    } cset_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic fault;
        logic has_top;
        logic clr_last;
    } cset_stat_t;

endpackage

[design/cset_ram.sv]
module cset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cset_ctrl.sv]
module cset_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output cset_pkg::cset_cmd_t  cmd,
    input  cset_pkg::cset_stat_t stat
);
    import cset_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_RDWAIT = 8'b0000_1000,
        S_POP    = 8'b0001_0000,
        S_ACC1   = 8'b0010_0000,
        S_ACC2RD = 8'b0100_0000,
        S_ACC2   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RES_ZERO;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.fault)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_FAULT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    unique case (stat.op)
                        OP_START:
                        begin
                            cmd.push   = 1'b1;
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        OP_READ:
                        begin
                            cmd.tot_rd_id = 1'b1;
                            state_next    = S_RDWAIT;
                        end
                        OP_END:
                        begin
                            cmd.stk_rd = 1'b1;
                            cmd.pop    = 1'b1;
                            state_next = S_POP;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                cmd.finish  = 1'b1;
                cmd.res_sel = RES_TOTAL;
                state_next  = S_IDLE;
            end
            S_POP:
            begin
                // Popped entry is on the stack read port; fetch the new top too.
                cmd.span_ld   = 1'b1;
                cmd.tot_rd_id = 1'b1;
                cmd.stk_rd    = 1'b1;
                state_next    = S_ACC1;
            end
            S_ACC1:
            begin
                cmd.tot_wr_add = 1'b1;
                cmd.top_ld     = 1'b1;
                if (stat.has_top)
                begin
                    state_next = S_ACC2RD;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_SPAN;
                    state_next  = S_IDLE;
                end
            end
            S_ACC2RD:
            begin
                cmd.tot_rd_top = 1'b1;
                state_next     = S_ACC2;
            end
            S_ACC2:
            begin
                cmd.tot_wr_sub = 1'b1;
                cmd.finish     = 1'b1;
                cmd.res_sel    = RES_SPAN;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/cset_dp.sv]
module cset_dp #(
    parameter int MAX_FUNCS   = cset_pkg::MAX_FUNCS_DEF,
    parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cset_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cset_pkg::cset_cmd_t               cmd,
    output cset_pkg::cset_stat_t              stat,
    input  logic [cset_pkg::OP_W-1:0]         op,
    input  logic [cset_pkg::ID_W-1:0]         func_id,
    input  logic [cset_pkg::TS_W-1:0]         timestamp,
    input  logic [cset_pkg::CFG_W-1:0]        num_funcs,
    output logic                              done,
    output logic [cset_pkg::ST_W-1:0]         status,
    output logic signed [cset_pkg::TOT_W-1:0] total
);
    import cset_pkg::*;

    localparam int TW  = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
    localparam int EW  = ID_W + TW;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int FAW = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;

    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TW-1:0]     t_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_dec;
    logic [FAW-1:0]    clr_reg;
    logic [FAW-1:0]    top_reg;
    logic [FAW-1:0]    id_idx;
    logic [TOT_W-1:0]  span_reg;
    logic [TOT_W-1:0]  span_next;
    logic              done_reg;
    status_t           status_reg;
    logic [TOT_W-1:0]  total_reg;

    logic              stk_en;
    logic              stk_we;
    logic [SAW-1:0]    stk_addr;
    logic [EW-1:0]     stk_wdata;
    logic [EW-1:0]     stk_rdata;

    logic              tot_en;
    logic              tot_we;
    logic [FAW-1:0]    tot_addr;
    logic [TOT_W-1:0]  tot_wdata;
    logic [TOT_W-1:0]  tot_rdata;

    logic              out_of_range;
    logic              full;
    logic              empty;
    status_t           fault_code;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg <= op_t'(op);
            id_reg <= func_id;
            t_reg  <= timestamp[TW-1:0];
        end
    end

    // Fault checks; the id range check takes priority over stack checks.
    assign out_of_range = ({1'b0, id_reg} >= num_funcs) || (32'(id_reg) >= 32'(MAX_FUNCS));
    assign full         = (count_reg == CW'(STACK_DEPTH));
    assign empty        = (count_reg == '0);

    always_comb
    begin
        fault_code = ST_OK;
        if (out_of_range)
        begin
            fault_code = ST_RANGE;
        end
        else if (op_reg == OP_START && full)
        begin
            fault_code = ST_FULL;
        end
        else if (op_reg == OP_END && empty)
        begin
            fault_code = ST_EMPTY;
        end
    end

    assign stat.op       = op_reg;
    assign stat.fault    = (op_reg != OP_NONE) && (fault_code != ST_OK);
    assign stat.has_top  = (count_reg != '0);
    assign stat.clr_last = (clr_reg == FAW'(MAX_FUNCS - 1));

    // Stack pointer and clearing-pass counter.
    assign count_dec = count_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_dec;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + FAW'(1);
            end
            done_reg <= cmd.finish;
        end
    end

    // Call stack: entries of id and entry time.
    assign stk_en    = cmd.push | cmd.stk_rd;
    assign stk_we    = cmd.push;
    assign stk_addr  = cmd.push ? count_reg[SAW-1:0] : count_dec[SAW-1:0];
    assign stk_wdata = {id_reg, t_reg};

    cset_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .en    (stk_en),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // Span of the ended call and the id of the caller left on top.
    assign span_next = TOT_W'(t_reg) - TOT_W'(stk_rdata[TW-1:0]) + TOT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.span_ld)
        begin
            span_reg <= span_next;
        end
        if (cmd.top_ld)
        begin
            top_reg <= FAW'(stk_rdata[EW-1:TW]);
        end
    end

    // Exclusive-time accumulators, each update a separate read and then a write.
    assign id_idx = FAW'(id_reg);
    assign tot_en = cmd.clr_wr | cmd.tot_rd_id | cmd.tot_wr_add | cmd.tot_rd_top
                  | cmd.tot_wr_sub;
    assign tot_we = cmd.clr_wr | cmd.tot_wr_add | cmd.tot_wr_sub;

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            tot_addr  = clr_reg;
            tot_wdata = '0;
        end
        else if (cmd.tot_rd_top || cmd.tot_wr_sub)
        begin
            tot_addr  = top_reg;
            tot_wdata = tot_rdata - span_reg;
        end
        else
        begin
            tot_addr  = id_idx;
            tot_wdata = tot_rdata + span_reg;
        end
    end

    cset_ram #(
        .WIDTH (TOT_W),
        .DEPTH (MAX_FUNCS)
    ) u_totals (
        .clk   (clk),
        .en    (tot_en),
        .we    (tot_we),
        .addr  (tot_addr),
        .wdata (tot_wdata),
        .rdata (tot_rdata)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= (cmd.res_sel == RES_FAULT) ? fault_code : ST_OK;
            case (cmd.res_sel)
                RES_SPAN:  total_reg <= span_reg;
                RES_TOTAL: total_reg <= tot_rdata;
                default:   total_reg <= '0;
            endcase
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign total  = signed'(total_reg);

endmodule

[design/call_stack_exclusive_time_unit.sv]
// Call-stack exclusive-time profiler. Each item is a trace event: a function
// start pushes its id and timestamp onto the call stack, a function end pops
// the top entry, forms span = end time - entry time + 1, adds the span to the
// ending id's accumulator and subtracts it from the accumulator of the caller
// left on top, and a read returns one accumulator. Every item produces exactly
// one result, shown on status and total for a single cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle. An item
// is accepted when start is high and busy is low. The block handles one item
// at a time, with busy high: a start, an unused op code or any faulty event
// passes through the check state only, a read through check and a read wait,
// and an end through check, pop and a first accumulate, plus a read and a
// write of the caller's accumulator when a caller remains, as the single-ported
// accumulator memory needs a separate read and write per update. Busy is also
// high after reset while all MAX_FUNCS accumulators (128 by default) are
// cleared; configuration writes are taken during that pass. Faults (id at or
// above num_funcs or MAX_FUNCS, start on a full stack, end on an empty stack)
// return total zero and change no state. The num_funcs register sits at byte
// address 0 of the APB port and must only be written while the block is idle.
module call_stack_exclusive_time_unit #(
    parameter int MAX_FUNCS   = cset_pkg::MAX_FUNCS_DEF,
    parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cset_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cset_pkg::OP_W-1:0]         op,
    input  logic [cset_pkg::ID_W-1:0]         func_id,
    input  logic [cset_pkg::TS_W-1:0]         timestamp,
    output logic                              done,
    output logic [cset_pkg::ST_W-1:0]         status,
    output logic signed [cset_pkg::TOT_W-1:0] total,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cset_pkg::PADDR_W-1:0]      paddr,
    input  logic [cset_pkg::PDATA_W-1:0]      pwdata,
    output logic [cset_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import cset_pkg::*;

    logic [CFG_W-1:0] num_funcs_reg;
    logic             cfg_wr;
    cset_cmd_t        cmd;
    cset_stat_t       stat;

    // The configuration port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NUM_FUNCS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_funcs_reg <= NUM_FUNCS_RST;
        end
        else if (cfg_wr)
        begin
            num_funcs_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Unmapped addresses read as zero.
    assign prdata = (paddr == ADDR_NUM_FUNCS) ? PDATA_W'(num_funcs_reg) : '0;

    // The controller sequences each item; the datapath holds the stack,
    // the accumulators and the result register.
    cset_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    cset_dp #(
        .MAX_FUNCS   (MAX_FUNCS),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .func_id   (func_id),
        .timestamp (timestamp),
        .num_funcs (num_funcs_reg),
        .done      (done),
        .status    (status),
        .total     (total)
    );

endmodule
